### rtl/bia_pkg.sv
// Package for the bitmap identifier allocator: request and response payload
// types, status and action codes, register indexes and controller states.
// Depends on nothing; used by the allocator and by anything driving its ports.
`default_nettype none

package bia_pkg;

    localparam int ID_W    = 16;
    localparam int CNT_W   = 11;
    localparam int IDX_W   = 12;   // bitmap index plus one bit of headroom
    localparam int STAT_W  = 2;

    localparam logic [ID_W-1:0]  ID_BASE_RESET  = 16'd300;
    localparam logic [CNT_W-1:0] ID_COUNT_RESET = 11'd101;

    localparam logic REG_ID_BASE  = 1'b0;
    localparam logic REG_ID_COUNT = 1'b1;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NONE_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd2;

    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] release_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]   granted_id;
        logic [STAT_W-1:0] status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_REL_DIV,
        ST_REL_RD,
        ST_REL_WR,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

### rtl/bitmap_id_allocator.sv
// Bitmap identifier allocator: usage bitmap in a one-port-read, one-port-write
// memory, first-free scan and release controller, and the APB register file.
// Depends on bia_pkg for payload types, codes and controller states.
// Allocate: from accept, words are read one per cycle through the memory read
// port (1 .. ceil(limit/WORD_BITS) words) until a free bit or the limit is found.
// Release: offset, divide by WORD_BITS, read, write back, result (out of range: result).
// One transaction at a time; the next request is taken once the result is
// registered. After reset a clearing pass writes zero to all
// ceil(MAX_IDS/WORD_BITS) words, one per cycle, before the first request.
`default_nettype none

module bitmap_id_allocator #(
    parameter int WORD_BITS = 64,
    parameter int MAX_IDS   = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire bia_pkg::req_t   req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output bia_pkg::rsp_t        rsp
);
    import bia_pkg::*;

    localparam int NUM_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int REC_SH    = 20;
    localparam int RECIP_W   = 18;
    localparam int PROD_W    = CNT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_L =
        RECIP_W'(((1 << REC_SH) + WORD_BITS - 1) / WORD_BITS);
    localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [ID_W:0]     MAX_IDS_L = (ID_W + 1)'(MAX_IDS);
    localparam logic [IDX_W-1:0]  WORD_STEP = IDX_W'(WORD_BITS);

    // configuration registers
    logic [ID_W-1:0]  base_reg;
    logic [CNT_W-1:0] count_reg;

    // controller
    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload registers
    logic [CNT_W-1:0]     lim_reg, lim_next;
    logic [AW-1:0]        word_reg, word_next;
    logic [IDX_W-1:0]     wbase_reg, wbase_next;
    logic [CNT_W-1:0]     off_reg, off_next;
    logic [AW-1:0]        q_reg, q_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic [ID_W-1:0]      grant_reg, grant_next;
    logic [STAT_W-1:0]    stat_reg, stat_next;
    rsp_t                 rsp_reg, rsp_next;

    // memory
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_re, mem_we;
    logic [AW-1:0]        mem_raddr, mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // datapath
    logic [ID_W:0]        avail;
    logic [ID_W:0]        lim_wide;
    logic [CNT_W-1:0]     lim_cur;
    logic [ID_W-1:0]      rel_off;
    logic                 rel_ok;
    logic [IDX_W-1:0]     rem;
    logic [WORD_BITS-1:0] cand;
    logic                 found;
    logic [BW-1:0]        fbit;
    logic                 scan_end;
    logic [PROD_W-1:0]    prod;
    logic                 accept;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ID_COUNT) ? {{(32 - CNT_W){1'b0}}, count_reg}
                                               : {{(32 - ID_W){1'b0}}, base_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= ID_BASE_RESET;
            count_reg <= ID_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_ID_BASE:  base_reg  <= pwdata[ID_W-1:0];
                REG_ID_COUNT: count_reg <= pwdata[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // usable size: least of count, capacity and room left above base
    always_comb
    begin
        avail    = (ID_W + 1)'(1 << ID_W) - {1'b0, base_reg};
        lim_wide = {{(ID_W + 1 - CNT_W){1'b0}}, count_reg};
        if (lim_wide > MAX_IDS_L)
        begin
            lim_wide = MAX_IDS_L;
        end
        if (lim_wide > avail)
        begin
            lim_wide = avail;
        end
        lim_cur = lim_wide[CNT_W-1:0];
        rel_off = req.release_id - base_reg;
        rel_ok  = (req.release_id >= base_reg) &&
                  (rel_off < {{(ID_W - CNT_W){1'b0}}, lim_cur});
    end

    // first free bit of the current word, below the limit
    always_comb
    begin
        rem = {1'b0, lim_reg} - wbase_reg;
        if ({1'b0, lim_reg} <= wbase_reg)
        begin
            rem = '0;
        end
        found = 1'b0;
        fbit  = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            cand[b] = !rd_data_reg[b] && (IDX_W'(b) < rem);
        end
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                found = 1'b1;
                fbit  = BW'(b);
            end
        end
        scan_end = (wbase_reg + WORD_STEP) >= {1'b0, lim_reg};
    end

    // offset / WORD_BITS by reciprocal multiply, exact for offsets below 2^CNT_W
    assign prod = PROD_W'(off_reg) * PROD_W'(RECIP_L);

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        lim_next       = lim_reg;
        word_next      = word_reg;
        wbase_next     = wbase_reg;
        off_next       = off_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        grant_next     = grant_reg;
        stat_next      = stat_reg;
        mem_re         = 1'b0;
        mem_raddr      = word_reg;
        mem_we         = 1'b0;
        mem_waddr      = q_reg;
        mem_wdata      = rd_data_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    lim_next   = lim_cur;
                    off_next   = rel_off[CNT_W-1:0];
                    grant_next = '0;
                    word_next  = '0;
                    wbase_next = '0;
                    if (req.action == ACT_ALLOC)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = ST_SCAN;
                    end
                    else if (rel_ok)
                    begin
                        stat_next  = STATUS_OK;
                        state_next = ST_REL_DIV;
                    end
                    else
                    begin
                        stat_next  = STATUS_RANGE;
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = word_reg;
                    mem_wdata  = rd_data_reg |
                                 ({{(WORD_BITS - 1){1'b0}}, 1'b1} << fbit);
                    grant_next = base_reg + ID_W'(wbase_reg) + ID_W'(fbit);
                    stat_next  = STATUS_OK;
                    state_next = ST_RESP;
                end
                else if (scan_end)
                begin
                    grant_next = '0;
                    stat_next  = STATUS_NONE_FREE;
                    state_next = ST_RESP;
                end
                else
                begin
                    // fetch the next word while this one is checked
                    mem_re     = 1'b1;
                    mem_raddr  = word_reg + 1'b1;
                    word_next  = word_reg + 1'b1;
                    wbase_next = wbase_reg + WORD_STEP;
                end
            end
            ST_REL_DIV:
            begin
                q_next     = AW'(prod >> REC_SH);
                state_next = ST_REL_RD;
            end
            ST_REL_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = q_reg;
                bit_next   = BW'(off_reg - CNT_W'(32'(q_reg) * WORD_BITS));
                state_next = ST_REL_WR;
            end
            ST_REL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = q_reg;
                mem_wdata  = rd_data_reg &
                             ~({{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_reg);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // hold until the output register is free or being drained
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.granted_id = grant_reg;
                    rsp_next.status     = stat_reg;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        lim_reg   <= lim_next;
        word_reg  <= word_next;
        wbase_reg <= wbase_next;
        off_reg   <= off_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
        grant_reg <= grant_next;
        stat_reg  <= stat_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.status == STATUS_OK ||
                           rsp_reg.status == STATUS_NONE_FREE ||
                           rsp_reg.status == STATUS_RANGE))
        else $error("response carries an undefined status");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != STATUS_OK) |-> rsp_reg.granted_id == '0)
        else $error("failed transaction returns a nonzero identifier");

    a_scan_align: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> wbase_reg == IDX_W'(32'(word_reg) * WORD_BITS))
        else $error("scan word index and bitmap base out of step");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_RESP) |-> !mem_we)
        else $error("bitmap written outside an allocate or release");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_CLEAR && state_reg != ST_CLEAR) |->
            $past(clr_reg) == LAST_WORD)
        else $error("clearing pass left early");

endmodule

`default_nettype wire
